// ----- design/u8d_pkg.sv -----
// Shared types and constants for the UTF-8 stream decoder.
package u8d_pkg;

    localparam int CP_W      = 21;
    localparam int BYTE_W    = 8;
    localparam int QDEPTH    = 4;
    localparam int QADDR_W   = $clog2(QDEPTH);
    localparam int QCNT_W    = QADDR_W + 1;

    localparam logic [CP_W-1:0] BAD_CHAR = 21'h00003F;

    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_LEN2 = 3'd2;
    localparam logic [2:0] SEQ_LEN3 = 3'd3;
    localparam logic [2:0] SEQ_LEN4 = 3'd4;

    // One decoded request: a run of replacement characters, then an optional final value.
    typedef struct packed {
        logic [1:0]      bad_count;
        logic            has_final;
        logic [CP_W-1:0] value;
    } u8d_cmd_t;

endpackage

// ----- design/u8d_front.sv -----
// Front end: accepts bytes, tracks the open sequence and classifies each byte.
module u8d_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic [7:0]              text_byte,
    input  logic                    q_full,
    output logic                    q_push,
    output u8d_pkg::u8d_cmd_t       q_cmd
);
    import u8d_pkg::*;

    logic [2:0]      exp_len_reg, exp_len_next;
    logic [1:0]      held_reg, held_next;
    logic [CP_W-1:0] part_reg, part_next;
    logic [CP_W-1:0] assembled;
    logic            accept;
    u8d_cmd_t        cmd;

    assign accept    = push && !q_full;
    assign assembled = {part_reg[CP_W-7:0], text_byte[5:0]};

    always_comb
    begin
        exp_len_next = exp_len_reg;
        held_next    = held_reg;
        part_next    = part_reg;
        cmd          = '0;
        if (exp_len_reg != SEQ_NONE && text_byte[7:6] == 2'b10)
        begin
            if ({1'b0, held_reg} + 3'd1 >= exp_len_reg)
            begin
                cmd.has_final = 1'b1;
                cmd.value     = assembled;
                exp_len_next  = SEQ_NONE;
                held_next     = 2'd0;
                part_next     = '0;
            end
            else
            begin
                held_next = held_reg + 2'd1;
                part_next = assembled;
            end
        end
        else
        begin
            // flush whatever the broken sequence held, then decode this byte fresh
            cmd.bad_count = (exp_len_reg != SEQ_NONE) ? held_reg : 2'd0;
            exp_len_next  = SEQ_NONE;
            held_next     = 2'd0;
            part_next     = '0;
            if (!text_byte[7])
            begin
                cmd.has_final = 1'b1;
                cmd.value     = {{(CP_W-BYTE_W){1'b0}}, text_byte};
            end
            else if (text_byte[7:5] == 3'b110)
            begin
                exp_len_next = SEQ_LEN2;
                held_next    = 2'd1;
                part_next    = {{(CP_W-5){1'b0}}, text_byte[4:0]};
            end
            else if (text_byte[7:4] == 4'b1110)
            begin
                exp_len_next = SEQ_LEN3;
                held_next    = 2'd1;
                part_next    = {{(CP_W-4){1'b0}}, text_byte[3:0]};
            end
            else if (text_byte[7:3] == 5'b11110)
            begin
                exp_len_next = SEQ_LEN4;
                held_next    = 2'd1;
                part_next    = {{(CP_W-3){1'b0}}, text_byte[2:0]};
            end
            else
            begin
                cmd.has_final = 1'b1;
                cmd.value     = BAD_CHAR;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_len_reg <= SEQ_NONE;
            held_reg    <= 2'd0;
            part_reg    <= '0;
        end
        else if (accept)
        begin
            exp_len_reg <= exp_len_next;
            held_reg    <= held_next;
            part_reg    <= part_next;
        end
    end

    // drop requests that produce no result (lead bytes, inner continuations)
    assign q_push = accept && (cmd.bad_count != 2'd0 || cmd.has_final);
    assign q_cmd  = cmd;

endmodule

// ----- design/u8d_queue.sv -----
// Short request queue between the front end and the back end.
module u8d_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_en,
    input  u8d_pkg::u8d_cmd_t       wr_cmd,
    output logic                    full,
    input  logic                    rd_en,
    output logic                    head_valid,
    output u8d_pkg::u8d_cmd_t       head_cmd
);
    import u8d_pkg::*;

    u8d_cmd_t             entry_reg [QDEPTH];
    logic [QADDR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]    count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !(rd_en && head_valid))
            count_next = count_reg + 1'b1;
        else if (!wr_en && rd_en && head_valid)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en && head_valid)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_reg[wr_ptr_reg] <= wr_cmd;
    end

endmodule

// ----- design/u8d_back.sv -----
// Back end: expands each request into results and holds them in the output register.
module u8d_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    head_valid,
    input  u8d_pkg::u8d_cmd_t       head_cmd,
    output logic                    head_pop,
    input  logic                    pop,
    output logic                    empty,
    output logic [u8d_pkg::CP_W-1:0] code_point,
    output logic                    last_of_run
);
    import u8d_pkg::*;

    logic            out_valid_reg;
    logic [CP_W-1:0] out_cp_reg, out_cp_next;
    logic            out_last_reg, out_last_next;
    logic [1:0]      bad_done_reg, bad_done_next;
    logic            load_ok, emit, in_bad;

    assign load_ok = !out_valid_reg || pop;
    assign emit    = head_valid && load_ok;
    assign in_bad  = bad_done_reg < head_cmd.bad_count;

    always_comb
    begin
        bad_done_next = bad_done_reg;
        head_pop      = 1'b0;
        if (in_bad)
        begin
            out_cp_next   = BAD_CHAR;
            out_last_next = (bad_done_reg + 2'd1 == head_cmd.bad_count) && !head_cmd.has_final;
        end
        else
        begin
            out_cp_next   = head_cmd.value;
            out_last_next = 1'b1;
        end
        if (emit)
        begin
            if (out_last_next)
            begin
                head_pop      = 1'b1;
                bad_done_next = 2'd0;
            end
            else
                bad_done_next = bad_done_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            bad_done_reg  <= 2'd0;
        end
        else
        begin
            bad_done_reg <= bad_done_next;
            if (load_ok)
                out_valid_reg <= head_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_cp_reg   <= out_cp_next;
            out_last_reg <= out_last_next;
        end
    end

    assign empty       = !out_valid_reg;
    assign code_point  = out_cp_reg;
    assign last_of_run = out_last_reg;

endmodule

// ----- design/utf8_stream_decoder.sv -----
// Top level of the streaming UTF-8 decoder.
// The decoder takes one text byte per cycle and returns code points through a
// queue-style result port. A plain byte, a finished multi-byte sequence, a
// stray continuation or an invalid lead gives one result; a lead byte or an
// inner continuation gives none; a byte that breaks an open sequence first
// gives one '?' per held byte, and a zero byte flushes held bytes as '?' and
// then returns code point 0. last_of_run marks the final result of a byte.
// Rate: one byte per cycle is accepted while the result side keeps up; the
// output register drains one result per cycle while pop is held, so a byte
// with n results holds the result port until all n are popped, and the four-entry
// request queue between the decode front end and the expanding back end
// absorbs such bursts before full rises. A result becomes visible once its
// request has been written into the queue and then loaded from the queue
// head into the output register.
module utf8_stream_decoder (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic [7:0]               text_byte,
    output logic                     empty,
    input  logic                     pop,
    output logic [u8d_pkg::CP_W-1:0] code_point,
    output logic                     last_of_run
);
    import u8d_pkg::*;

    logic     q_push, q_full, head_valid, head_pop;
    u8d_cmd_t q_cmd, head_cmd;

    // Front end: hold the open sequence and turn each byte into a request.
    u8d_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .text_byte (text_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    // Request queue: decouple decode from result expansion.
    u8d_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (q_push),
        .wr_cmd     (q_cmd),
        .full       (q_full),
        .rd_en      (head_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Back end: advance through each request one result per cycle while the output register is empty or popped.
    u8d_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_cmd    (head_cmd),
        .head_pop    (head_pop),
        .pop         (pop),
        .empty       (empty),
        .code_point  (code_point),
        .last_of_run (last_of_run)
    );

    assign full = q_full;

    // Only replacement characters of a flush can precede the last result of a byte.
    a_nonlast_is_bad: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !last_of_run) |-> (code_point == BAD_CHAR))
        else $error("non-final result is not a replacement character");

    // A full queue always has a request at its head.
    a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> head_valid)
        else $error("queue full without a head request");

    // The back end never pops an empty queue.
    a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        head_pop |-> head_valid)
        else $error("request popped from an empty queue");

endmodule

// ----- tb/sv/utf8_decode_checker.sv -----
// Scoreboard for the UTF-8 stream decoder: predicts code points per byte and checks results.
module utf8_decode_checker (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  logic                     full,
    input  logic [7:0]               text_byte,
    input  logic                     empty,
    input  logic                     pop,
    input  logic [u8d_pkg::CP_W-1:0] code_point,
    input  logic                     last_of_run,
    output int                       fail_count,
    output int                       pending_count,
    output int                       checked_count
);
    import u8d_pkg::*;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            is_last;
    } point_t;

    point_t          expected_points[$];
    point_t          oldest_point;
    logic [2:0]      seq_len;
    logic [1:0]      held_bytes;
    logic [CP_W-1:0] partial_cp;

    // Work out the code points one accepted byte produces and queue them.
    task automatic decode_byte(input logic [7:0] b);
        logic [CP_W-1:0] points [4];
        int              n;
        logic            fresh;
        n = 0;
        fresh = 1'b1;
        if (seq_len != SEQ_NONE) begin
            if (b[7:6] == 2'b10) begin
                fresh = 1'b0;
                partial_cp = {partial_cp[CP_W-7:0], b[5:0]};
                if (int'(held_bytes) + 1 >= int'(seq_len)) begin
                    points[n] = partial_cp;
                    n = n + 1;
                    seq_len = SEQ_NONE;
                    held_bytes = 2'd0;
                    partial_cp = '0;
                end
                else begin
                    held_bytes = held_bytes + 2'd1;
                end
            end
            else begin
                // broken sequence: one replacement per held byte, then rescan
                for (int i = 0; i < int'(held_bytes); i++) begin
                    points[n] = BAD_CHAR;
                    n = n + 1;
                end
                seq_len = SEQ_NONE;
                held_bytes = 2'd0;
                partial_cp = '0;
            end
        end
        if (fresh) begin
            if (b == 8'h00) begin
                points[n] = '0;
                n = n + 1;
            end
            else if (!b[7]) begin
                points[n] = CP_W'(b);
                n = n + 1;
            end
            else if (b[7:5] == 3'b110) begin
                seq_len = SEQ_LEN2;
                held_bytes = 2'd1;
                partial_cp = CP_W'(b[4:0]);
            end
            else if (b[7:4] == 4'b1110) begin
                seq_len = SEQ_LEN3;
                held_bytes = 2'd1;
                partial_cp = CP_W'(b[3:0]);
            end
            else if (b[7:3] == 5'b11110) begin
                seq_len = SEQ_LEN4;
                held_bytes = 2'd1;
                partial_cp = CP_W'(b[2:0]);
            end
            else begin
                points[n] = BAD_CHAR;
                n = n + 1;
            end
        end
        for (int i = 0; i < n; i++)
            expected_points.push_back(point_t'{cp: points[i], is_last: (i == n - 1)});
    endtask

    // Compare results before predicting, so a result never meets its own byte's prediction.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            seq_len = SEQ_NONE;
            held_bytes = 2'd0;
            partial_cp = '0;
            expected_points.delete();
            fail_count = 0;
            checked_count = 0;
        end
        else begin
            if (pop && !empty) begin
                if (expected_points.size() == 0) begin
                    $error("unexpected result: code_point %0h last_of_run %0b",
                           code_point, last_of_run);
                    fail_count = fail_count + 1;
                end
                else begin
                    oldest_point = expected_points.pop_front();
                    checked_count = checked_count + 1;
                    if (code_point !== oldest_point.cp) begin
                        $error("code_point: expected %0h, got %0h",
                               oldest_point.cp, code_point);
                        fail_count = fail_count + 1;
                    end
                    if (last_of_run !== oldest_point.is_last) begin
                        $error("last_of_run: expected %0b, got %0b",
                               oldest_point.is_last, last_of_run);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (push && !full)
                decode_byte(text_byte);
        end
        pending_count = expected_points.size();
    end

endmodule

// ----- tb/sv/tb_utf8_stream_decoder.sv -----
// Testbench top for the UTF-8 stream decoder: byte stimulus, result draining and verdict.
module tb_utf8_stream_decoder;
    import u8d_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 260;
    localparam int DRAIN_CYCLES = 8;
    localparam int N_DIRECTED   = 23;

    logic            clk = 1'b0;
    logic            rst_n;
    logic            push = 1'b0;
    logic [7:0]      text_byte = 8'h00;
    logic            pop = 1'b0;
    logic            full;
    logic            empty;
    logic [CP_W-1:0] code_point;
    logic            last_of_run;

    int fail_count;
    int pending_count;
    int checked_count;
    int cycle_count = 0;
    int bytes_sent = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    // Directed text: plain bytes at both ends, three- and four-byte sequences at the
    // largest payloads, an overlong form, stray continuations, invalid leads,
    // a sequence broken by a plain byte, one broken by a new lead, a zero
    // flushing three held bytes, and a lone zero.
    logic [7:0] directed_bytes [N_DIRECTED] = '{
        8'h41, 8'h7F, 8'hC0, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hF7,
        8'hBF, 8'hBF, 8'hBF, 8'h80, 8'hF8, 8'hFF, 8'hE2, 8'h82,
        8'h41, 8'hC3, 8'hF0, 8'h9F, 8'h98, 8'h00, 8'h00
    };

    utf8_stream_decoder u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .text_byte   (text_byte),
        .empty       (empty),
        .pop         (pop),
        .code_point  (code_point),
        .last_of_run (last_of_run)
    );

    utf8_decode_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .text_byte     (text_byte),
        .empty         (empty),
        .pop           (pop),
        .code_point    (code_point),
        .last_of_run   (last_of_run),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: drop pop at random at the current idle rate.
    always @(posedge clk)
    begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Watchdog: end the run if the stream stalls for good.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count = cycle_count + 1;
        end
        $display("FAIL");
        $finish;
    end

    // Offer one byte after a random idle gap; hold it until the decoder takes it.
    // Call and return at a rising edge; push stays high into the next request.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        text_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        bytes_sent = bytes_sent + 1;
    endtask

    // Hold off the sender until every predicted code point has been popped.
    task automatic drain_results();
        push <= 1'b0;
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Send one run of text: mostly well-formed characters with random payload,
    // some sequences broken early, some raw noise bytes and some end-of-text zeros.
    task automatic send_run();
        int         kind;
        int         len;
        int         keep;
        logic [7:0] lead;
        logic [7:0] breaker;
        kind = $urandom_range(99);
        if (kind < 80) begin
            len = (kind < 65) ? $urandom_range(4, 1) : $urandom_range(4, 2);
            case (len)
                1: lead = 8'($urandom_range(127, 1));
                2: lead = {3'b110, 5'($urandom)};
                3: lead = {4'b1110, 4'($urandom)};
                default: lead = {5'b11110, 3'($urandom)};
            endcase
            send_byte(lead);
            keep = (kind < 65) ? len - 1 : $urandom_range(len - 2, 0);
            for (int i = 0; i < keep; i++)
                send_byte({2'b10, 6'($urandom)});
            if (kind >= 65) begin
                // break the sequence with anything but a continuation
                case ($urandom_range(3))
                    0: breaker = 8'h00;
                    1: breaker = 8'($urandom_range(127, 1));
                    2: breaker = 8'($urandom_range(255, 192));
                    default:
                    begin
                        do
                            breaker = 8'($urandom);
                        while (breaker[7:6] == 2'b10);
                    end
                endcase
                send_byte(breaker);
            end
        end
        else if (kind < 92) begin
            send_byte(8'($urandom));
        end
        else begin
            send_byte(8'h00);
        end
    endtask

    initial
    begin
        // Hold reset low, then release it at an edge.
        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed text with a slow receiver.
        tx_idle_pct = 37;
        rx_idle_pct = 88;
        for (int i = 0; i < N_DIRECTED; i++)
            send_byte(directed_bytes[i]);
        drain_results();

        // Random text in three idle mixes; drain fully between them.
        while (bytes_sent < N_DIRECTED + RANDOM_BYTES / 3)
            send_run();
        drain_results();

        tx_idle_pct = 88;
        rx_idle_pct = 37;
        while (bytes_sent < N_DIRECTED + 2 * RANDOM_BYTES / 3)
            send_run();
        drain_results();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        while (bytes_sent < N_DIRECTED + RANDOM_BYTES)
            send_run();

        // Wait for the last predicted code point, then let the pipeline settle
        // so any stray extra result still gets caught.
        push <= 1'b0;
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Stream covered %0d bytes (%0d directed) under three idle mixes",
                 bytes_sent, N_DIRECTED);
        $display("Checked %0d decoded code points against the predictor", checked_count);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
